>>> hw/rtl/polygon_ring_area_centroid_macros.svh
// assertion macros for the polygon ring area and centroid block
// used by the port checker, no other dependencies
`ifndef POLYGON_RING_AREA_CENTROID_MACROS_SVH
`define POLYGON_RING_AREA_CENTROID_MACROS_SVH

// same-cycle implication
`define PRAC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prac check failed");

// next-cycle implication
`define PRAC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prac check failed");

`endif

>>> hw/rtl/prac_pkg.sv
// shared constants, status codes and controller interface types
// no dependencies
package prac_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF   = 16;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned PROD_W      = 32;
  localparam int unsigned PAIR_W      = 17;
  localparam int unsigned CROSS_W     = 33;
  localparam int unsigned WPROD_W     = 50;
  localparam int unsigned CROSS_SUM_W = 44;
  localparam int unsigned WSUM_W      = 61;
  localparam int unsigned CSUM_W      = 27;
  localparam int unsigned AREA_W      = 35;
  localparam int unsigned CEN_W       = 24;
  localparam int unsigned NUM_W       = 61;
  localparam int unsigned DEN_W       = 46;
  localparam int unsigned Q_W         = 25;
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned Q_STEPS     = 24;
  localparam int unsigned SAT_SHIFT   = Q_STEPS - FRAC_BITS;
  localparam int unsigned STEP_W      = 5;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FEW  = 2'd1;
  localparam logic [1:0] STAT_MEAN = 2'd2;
  localparam logic [1:0] STAT_MANY = 2'd3;

  localparam logic signed [CROSS_SUM_W-1:0] AREA_LIMIT = 44'sd8589934592;
  localparam logic [Q_W-1:0]   Q_HALF  = 25'd8388608;
  localparam logic [CEN_W-1:0] CEN_MAX = 24'h7fffff;
  localparam logic [CEN_W-1:0] CEN_MIN = 24'h800000;

  typedef struct packed {
    logic accept;
    logic mul;
    logic acc;
    logic close;
    logic special;
    logic setup_x;
    logic setup_y;
    logic div_start;
    logic store_x;
    logic store_y;
    logic emit;
  } prac_cmd_t;

  typedef struct packed {
    logic count_over;
    logic count_low;
    logic div_done;
    logic out_free;
  } prac_stat_t;

endpackage

>>> hw/rtl/prac_div.sv
// restoring divider, one quotient bit per cycle, q = min(num*256/den, 2^24)
// depends on prac_pkg
module prac_div
  import prac_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   q,
  output logic             done
);

  logic               busy;
  logic [DEN_W-1:0]   rem;
  logic [DEN_W-1:0]   den_r;
  logic [Q_STEPS-1:0] low;
  logic [STEP_W-1:0]  steps;
  logic [DEN_W:0]     rem2;
  logic               ge;
  logic               sat;

  assign sat  = {1'b0, num} >= {den, SAT_SHIFT'(0)};
  assign rem2 = {rem, low[Q_STEPS-1]};
  assign ge   = rem2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den_r <= den;
        if (sat) begin
          q    <= Q_W'(1) << Q_STEPS;
          done <= 1'b1;
        end else begin
          q     <= '0;
          rem   <= DEN_W'(num >> SAT_SHIFT);
          low   <= {num[SAT_SHIFT-1:0], FRAC_BITS'(0)};
          steps <= STEP_W'(Q_STEPS);
          busy  <= 1'b1;
        end
      end else if (busy) begin
        rem   <= ge ? DEN_W'(rem2 - {1'b0, den_r}) : rem2[DEN_W-1:0];
        low   <= low << 1;
        q     <= {q[Q_W-2:0], ge};
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/prac_ctrl.sv
// ring sequencer: vertex intake, closing edge, two divisions, result hand-off
// depends on prac_pkg
module prac_ctrl
  import prac_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tlast,
  output logic       s_tready,
  input  prac_stat_t stat,
  output prac_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_FIN  = 4'd3;
  localparam logic [3:0] S_CMUL = 4'd4;
  localparam logic [3:0] S_CACC = 4'd5;
  localparam logic [3:0] S_SETX = 4'd6;
  localparam logic [3:0] S_STX  = 4'd7;
  localparam logic [3:0] S_DIVX = 4'd8;
  localparam logic [3:0] S_SETY = 4'd9;
  localparam logic [3:0] S_STY  = 4'd10;
  localparam logic [3:0] S_DIVY = 4'd11;
  localparam logic [3:0] S_EMIT = 4'd12;

  logic [3:0] state, state_next;
  logic       pend_last;
  logic       accept;

  assign s_tready = (state == S_IDLE) || (state == S_ACC && !pend_last);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend_last <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) pend_last <= s_tlast;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.accept = accept;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (pend_last) state_next = S_FIN;
        else if (accept) state_next = S_MUL;
        else state_next = S_IDLE;
      end
      S_FIN: begin
        if (stat.count_over || stat.count_low) begin
          cmd.special = 1'b1;
          state_next  = S_EMIT;
        end else begin
          cmd.close  = 1'b1;
          state_next = S_CMUL;
        end
      end
      S_CMUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CACC;
      end
      S_CACC: begin
        cmd.acc    = 1'b1;
        state_next = S_SETX;
      end
      S_SETX: begin
        cmd.setup_x = 1'b1;
        state_next  = S_STX;
      end
      S_STX: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVX;
      end
      S_DIVX: begin
        if (stat.div_done) begin
          cmd.store_x = 1'b1;
          state_next  = S_SETY;
        end
      end
      S_SETY: begin
        cmd.setup_y = 1'b1;
        state_next  = S_STY;
      end
      S_STY: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVY;
      end
      S_DIVY: begin
        if (stat.div_done) begin
          cmd.store_y = 1'b1;
          state_next  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/prac_dp.sv
// datapath: ring sums, edge products, divider operands and output register
// depends on prac_pkg and prac_div
module prac_dp
  import prac_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  prac_cmd_t                  cmd,
  input  logic signed [COORD_W-1:0]  in_x,
  input  logic signed [COORD_W-1:0]  in_y,
  input  logic                       out_ready,
  output prac_stat_t                 stat,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [AREA_W-1:0]          out_area,
  output logic                       out_cw,
  output logic [CEN_W-1:0]           out_cx,
  output logic [CEN_W-1:0]           out_cy
);

  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 2);
  localparam int unsigned SHIFT = COORD_W - COORD_BITS;

  logic signed [COORD_W-1:0]     xs, ys;
  logic signed [COORD_W-1:0]     first_x, first_y, prev_x, prev_y;
  logic [CNT_W-1:0]              count;
  logic signed [CROSS_SUM_W-1:0] cross_sum;
  logic signed [WSUM_W-1:0]      wsum_x, wsum_y;
  logic signed [CSUM_W-1:0]      csum_x, csum_y;
  logic signed [PROD_W-1:0]      p1, p2;
  logic signed [PAIR_W-1:0]      sx, sy;
  logic signed [CROSS_W-1:0]     c, c_comb;
  logic signed [WPROD_W-1:0]     wx, wy, wx_comb, wy_comb;

  logic [NUM_W-1:0]              div_num;
  logic [DEN_W-1:0]              div_den;
  logic                          div_neg;
  logic [Q_W-1:0]                div_q;
  logic                          div_done;

  logic [1:0]                    res_status;
  logic [AREA_W-1:0]             res_area;
  logic                          res_cw;
  logic [CEN_W-1:0]              res_cx, res_cy;

  logic                          cross_zero;
  logic [CROSS_SUM_W-1:0]        cross_mag;
  logic [WSUM_W-1:0]             wmag_x, wmag_y;
  logic [CSUM_W-1:0]             cmag_x, cmag_y;
  logic signed [CROSS_SUM_W-1:0] area_clamp;
  logic [CEN_W-1:0]              cen_val;

  assign xs = (in_x <<< SHIFT) >>> SHIFT;
  assign ys = (in_y <<< SHIFT) >>> SHIFT;

  assign c_comb  = CROSS_W'(p1) - CROSS_W'(p2);
  assign wx_comb = sx * c_comb;
  assign wy_comb = sy * c_comb;

  assign cross_zero = cross_sum == '0;
  assign cross_mag  = cross_sum[CROSS_SUM_W-1] ? ~cross_sum + 1'b1 : cross_sum;
  assign wmag_x     = wsum_x[WSUM_W-1] ? ~wsum_x + 1'b1 : wsum_x;
  assign wmag_y     = wsum_y[WSUM_W-1] ? ~wsum_y + 1'b1 : wsum_y;
  assign cmag_x     = csum_x[CSUM_W-1] ? ~csum_x + 1'b1 : csum_x;
  assign cmag_y     = csum_y[CSUM_W-1] ? ~csum_y + 1'b1 : csum_y;

  always_comb begin
    if (cross_sum > AREA_LIMIT) area_clamp = AREA_LIMIT;
    else if (cross_sum < -AREA_LIMIT) area_clamp = -AREA_LIMIT;
    else area_clamp = cross_sum;
  end

  always_comb begin
    if (div_neg) cen_val = (div_q >= Q_HALF) ? CEN_MIN : ~div_q[CEN_W-1:0] + 1'b1;
    else cen_val = (div_q >= Q_HALF) ? CEN_MAX : div_q[CEN_W-1:0];
  end

  assign stat.count_over = count > CNT_W'(MAX_VERTICES);
  assign stat.count_low  = count < CNT_W'(3);
  assign stat.div_done   = div_done;
  assign stat.out_free   = !out_valid || out_ready;

  prac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .q     (div_q),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      first_x   <= '0;
      first_y   <= '0;
      prev_x    <= '0;
      prev_y    <= '0;
      count     <= '0;
      cross_sum <= '0;
      wsum_x    <= '0;
      wsum_y    <= '0;
      csum_x    <= '0;
      csum_y    <= '0;
    end else begin
      if (cmd.accept) begin
        if (count < CNT_W'(MAX_VERTICES)) begin
          if (count == '0) begin
            first_x <= xs;
            first_y <= ys;
          end
          prev_x <= xs;
          prev_y <= ys;
          csum_x <= csum_x + CSUM_W'(xs);
          csum_y <= csum_y + CSUM_W'(ys);
          count  <= count + CNT_W'(1);
        end else begin
          count <= CNT_W'(MAX_VERTICES + 1);
        end
      end
      if (cmd.acc) begin
        cross_sum <= cross_sum + CROSS_SUM_W'(c);
        wsum_x    <= wsum_x + WSUM_W'(wx);
        wsum_y    <= wsum_y + WSUM_W'(wy);
      end
    end
  end

  // edge operands; first and frozen vertices contribute a null edge
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (count != '0 && count < CNT_W'(MAX_VERTICES)) begin
        p1 <= prev_x * ys;
        p2 <= xs * prev_y;
        sx <= {prev_x[COORD_W-1], prev_x} + {xs[COORD_W-1], xs};
        sy <= {prev_y[COORD_W-1], prev_y} + {ys[COORD_W-1], ys};
      end else begin
        p1 <= '0;
        p2 <= '0;
        sx <= '0;
        sy <= '0;
      end
    end else if (cmd.close) begin
      p1 <= prev_x * first_y;
      p2 <= first_x * prev_y;
      sx <= {prev_x[COORD_W-1], prev_x} + {first_x[COORD_W-1], first_x};
      sy <= {prev_y[COORD_W-1], prev_y} + {first_y[COORD_W-1], first_y};
    end
    if (cmd.mul) begin
      c  <= c_comb;
      wx <= wx_comb;
      wy <= wy_comb;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.special) begin
      res_status <= stat.count_over ? STAT_MANY : STAT_FEW;
      res_area   <= '0;
      res_cw     <= 1'b0;
      res_cx     <= '0;
      res_cy     <= '0;
    end
    if (cmd.setup_x) begin
      if (cross_zero) begin
        res_status <= STAT_MEAN;
        res_area   <= '0;
        res_cw     <= 1'b0;
        div_num    <= NUM_W'(cmag_x);
        div_den    <= DEN_W'(count);
        div_neg    <= csum_x[CSUM_W-1];
      end else begin
        res_status <= STAT_OK;
        res_area   <= area_clamp[AREA_W-1:0];
        res_cw     <= cross_sum[CROSS_SUM_W-1];
        div_num    <= wmag_x;
        div_den    <= DEN_W'(cross_mag) + (DEN_W'(cross_mag) << 1);
        div_neg    <= wsum_x[WSUM_W-1] ^ cross_sum[CROSS_SUM_W-1];
      end
    end
    if (cmd.setup_y) begin
      if (cross_zero) begin
        div_num <= NUM_W'(cmag_y);
        div_neg <= csum_y[CSUM_W-1];
      end else begin
        div_num <= wmag_y;
        div_neg <= wsum_y[WSUM_W-1] ^ cross_sum[CROSS_SUM_W-1];
      end
    end
    if (cmd.store_x) res_cx <= cen_val;
    if (cmd.store_y) res_cy <= cen_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= res_status;
      out_area   <= res_area;
      out_cw     <= res_cw;
      out_cx     <= res_cx;
      out_cy     <= res_cy;
    end
  end

endmodule

>>> hw/rtl/polygon_ring_area_centroid.sv
// Shoelace area and centroid of one polygon ring per run of vertices. A vertex
// word is taken only when the one before it is through: the accept cycle forms
// the two cross products, the next forms the weighted products, and the sums
// are updated in the cycle that can take the following vertex. After the
// vertex marked last, a ring with too few or too many vertices goes straight
// to its result; otherwise the closing edge is added, then the centroid x and
// y go one after the other through one shared restoring divider (ended at once
// when the quotient saturates). Only then does the result word appear and the
// next ring can start. The result word sits in an output register until taken.
// depends on prac_pkg, prac_ctrl, prac_dp
module polygon_ring_area_centroid
  import prac_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS   = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // vertex_x, vertex_y
  input  logic        s_tlast,   // last_vertex
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // area_doubled, clockwise, centroid_x, centroid_y, pad
  output logic [1:0]  m_tuser    // status
);

  prac_cmd_t         cmd;
  prac_stat_t        stat;
  logic [AREA_W-1:0] area;
  logic              cw;
  logic [CEN_W-1:0]  cx, cy;

  prac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  prac_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_x       (s_tdata[15:0]),
    .in_y       (s_tdata[31:16]),
    .out_ready  (m_tready),
    .stat       (stat),
    .out_valid  (m_tvalid),
    .out_status (m_tuser),
    .out_area   (area),
    .out_cw     (cw),
    .out_cx     (cx),
    .out_cy     (cy)
  );

  assign m_tdata = {4'b0, cy, cx, cw, area};

endmodule

>>> hw/rtl/prac_checker.sv
// port-level checks on the result stream, bound to the top level
// depends on prac_pkg and the assertion macro header
`include "polygon_ring_area_centroid_macros.svh"

module prac_checker
  import prac_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata,
  input logic [1:0]  m_tuser
);

  `PRAC_ASSERT_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `PRAC_ASSERT_NEXT(a_hold_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))
  `PRAC_ASSERT_NOW(a_special_zero, clk, rst,
    m_tvalid && (m_tuser == STAT_FEW || m_tuser == STAT_MANY), m_tdata[83:0] == '0)
  `PRAC_ASSERT_NOW(a_mean_no_area, clk, rst,
    m_tvalid && m_tuser == STAT_MEAN, m_tdata[35:0] == '0)
  `PRAC_ASSERT_NOW(a_cw_sign, clk, rst, m_tvalid, m_tdata[35] == m_tdata[34])

endmodule

bind polygon_ring_area_centroid prac_checker u_prac_checker (.*);

>>> tb/sv/polygon_ring_area_centroid_tb.sv
// testbench for polygon_ring_area_centroid: streams vertex rings and checks
// area, winding, centroid and status of each ring against a built-in predictor
// depends on prac_pkg and the polygon_ring_area_centroid rtl
module polygon_ring_area_centroid_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prac_pkg::*;

  localparam int MAX_V = 1024;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [34:0] area;
    logic               cw;
    logic signed [23:0] cen_x;
    logic signed [23:0] cen_y;
  } ring_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic [1:0] m_tuser;

  // ring accumulators of the predictor
  longint fx, fy, px, py, csum, wsx, wsy, sx, sy;
  int unsigned nvert;

  ring_result_t pending_rings[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  polygon_ring_area_centroid uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void clear_ring();
    fx = 0; fy = 0; px = 0; py = 0; csum = 0; wsx = 0; wsy = 0; sx = 0; sy = 0;
    nvert = 0;
  endfunction

  function automatic void add_edge(longint x0, longint y0, longint x1, longint y1);
    longint c;
    c = x0 * y1 - x1 * y0;
    csum += c;
    wsx += (x0 + x1) * c;
    wsy += (y0 + y1) * c;
  endfunction

  function automatic logic signed [23:0] q8_quot(longint num, longint den, bit neg);
    longint unsigned n, d, q1, r, q;
    n = (num < 0) ? -num : num;
    d = den;
    q1 = n / d;
    r = n % d;
    if (q1 >= 64'd16777216) q = 64'd16777216;
    else q = (q1 << 8) + ((r << 8) / d);
    if (neg) begin
      if (q > 64'd8388608) return 24'sh800000;
      return -$signed(q[23:0]);
    end
    if (q > 64'd8388607) return 24'sh7fffff;
    return q[23:0];
  endfunction

  function automatic void predict_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
                                         bit last);
    ring_result_t res;
    longint x, y, den;
    bit cneg;
    x = vx;
    y = vy;
    if (nvert < MAX_V) begin
      if (nvert == 0) begin
        fx = x; fy = y;
      end else begin
        add_edge(px, py, x, y);
      end
      px = x; py = y; sx += x; sy += y;
      nvert++;
    end else begin
      nvert = MAX_V + 1;
    end
    if (!last) return;
    res = '0;
    if (nvert > MAX_V) begin
      res.status = STAT_MANY;
    end else if (nvert < 3) begin
      res.status = STAT_FEW;
    end else begin
      add_edge(px, py, fx, fy);
      if (csum == 0) begin
        res.status = STAT_MEAN;
        res.cen_x = q8_quot(sx, nvert, sx < 0);
        res.cen_y = q8_quot(sy, nvert, sy < 0);
      end else begin
        res.status = STAT_OK;
        cneg = csum < 0;
        den = 3 * (cneg ? -csum : csum);
        if (csum > 64'sd8589934592) res.area = 35'sd8589934592;
        else if (csum < -64'sd8589934592) res.area = -35'sd8589934592;
        else res.area = csum;
        res.cw = cneg;
        res.cen_x = q8_quot(wsx, den, (wsx < 0) != cneg);
        res.cen_y = q8_quot(wsy, den, (wsy < 0) != cneg);
      end
    end
    pending_rings.push_back(res);
    clear_ring();
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic send_vertex(logic signed [15:0] vx, logic signed [15:0] vy, bit last);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {vy, vx};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_vertex(vx, vy, last);
  endtask

  // random ready with per-word stall
  initial begin
    int stall;
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    ring_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_rings.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = pending_rings.pop_front();
        if (m_tuser !== want.status) report_mismatch("status", m_tuser, want.status);
        if ($signed(m_tdata[34:0]) !== want.area)
          report_mismatch("area_doubled", $signed(m_tdata[34:0]), want.area);
        if (m_tdata[35] !== want.cw) report_mismatch("clockwise", m_tdata[35], want.cw);
        if ($signed(m_tdata[59:36]) !== want.cen_x)
          report_mismatch("centroid_x", $signed(m_tdata[59:36]), want.cen_x);
        if ($signed(m_tdata[83:60]) !== want.cen_y)
          report_mismatch("centroid_y", $signed(m_tdata[83:60]), want.cen_y);
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_ring(int n, int span, longint cx, longint cy);
    longint x, y;
    for (int i = 0; i < n; i++) begin
      x = cx + $signed($urandom_range(0, 2 * span)) - span;
      y = cy + $signed($urandom_range(0, 2 * span)) - span;
      if (x > 32767) x = 32767;
      if (x < -32768) x = -32768;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      send_vertex(16'(x), 16'(y), i == n - 1);
    end
  endtask

  task automatic test_basic_shapes();
    send_vertex(0, 0, 0); send_vertex(10, 0, 0); send_vertex(10, 10, 0);
    send_vertex(0, 10, 1);
    send_vertex(0, 0, 0); send_vertex(0, 10, 0); send_vertex(10, 10, 0);
    send_vertex(10, 0, 1);
  endtask

  task automatic test_short_rings();
    send_vertex(5, -5, 1);
    send_vertex(-1, 2, 0); send_vertex(3, 4, 1);
  endtask

  task automatic test_zero_area();
    send_vertex(-7, -3, 0); send_vertex(1, 1, 0); send_vertex(9, 5, 1);
    send_vertex(4, 4, 0); send_vertex(4, 4, 0); send_vertex(4, 4, 1);
  endtask

  task automatic test_extremes();
    send_vertex(-32768, -32768, 0); send_vertex(32767, -32768, 0);
    send_vertex(32767, 32767, 0); send_vertex(-32768, 32767, 1);
    // self-crossing ring far off center has zero area, so the centroid is the vertex mean
    send_vertex(32767, 32767, 0); send_vertex(32766, 32767, 0);
    send_vertex(32767, 32766, 0); send_vertex(32766, 32766, 1);
  endtask

  task automatic test_too_many();
    send_ring(MAX_V + 2, 30000, 0, 0);
  endtask

  task automatic test_random_rings();
    int sent, n, kind;
    sent = 0;
    while (sent < 200) begin
      kind = $urandom_range(0, 9);
      n = (kind == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      if (kind == 1) send_ring(n, 32767, 0, 0);
      else if (kind == 2) send_ring(n, 3, $signed($urandom_range(0, 60000)) - 30000, 0);
      else send_ring(n, $urandom_range(1, 2000),
                     $signed($urandom_range(0, 40000)) - 20000,
                     $signed($urandom_range(0, 40000)) - 20000);
      sent += n;
    end
  endtask

  initial begin
    clear_ring();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_basic_shapes();
    test_short_rings();
    test_zero_area();
    test_extremes();
    test_random_rings();
    test_too_many();
    s_tvalid <= 1'b0;
    while (pending_rings.size() != 0) @(posedge clk);
    stim_done = 1'b1;
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
